### hw/rtl/bytes_to_radix_digits_encoder_top_assert.svh
// assertion macros for the radix digit encoder
`ifndef BYTES_TO_RADIX_DIGITS_ENCODER_TOP_ASSERT_SVH
`define BYTES_TO_RADIX_DIGITS_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BDRE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdre assertion failed");

// next-cycle implication, checked outside reset
`define BDRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdre assertion failed");

`endif

### hw/rtl/bdre_pkg.sv
// shared types, codes and alphabet lookup for the radix digit encoder
`default_nettype none
package bdre_pkg;

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;

    localparam logic [0:0] REG_BASE_SELECT   = 1'b0;
    localparam logic [0:0] REG_OUTPUT_LENGTH = 1'b1;

    localparam logic [6:0] CHAR_ZERO = 7'h30;

    localparam logic [6:0] C32_ALPHA [32] = '{
        7'h31, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
        7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
        7'h49, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51,
        7'h52, 7'h53, 7'h54, 7'h55, 7'h57, 7'h58, 7'h59, 7'h5A
    };

    typedef struct packed {
        logic en;
        logic clr;
    } cell_ctl_t;

    function automatic logic [6:0] alpha_char(input logic [1:0] base_sel,
                                              input logic [4:0] digit);
        logic [6:0] ch;
        case (base_sel)
            BASE_BIN: ch = CHAR_ZERO + {2'b00, digit};
            BASE_DEC: ch = CHAR_ZERO + {2'b00, digit};
            default:  ch = C32_ALPHA[digit];
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/bdre_cell.sv
// one storage cell of a shift chain, loads from its neighbor when enabled
`default_nettype none
module bdre_cell #(
    parameter int W = 8
) (
    input  wire logic                 clk,
    input  wire bdre_pkg::cell_ctl_t  ctl,
    input  wire logic [W-1:0]         d,
    output logic [W-1:0]              q
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.en)
        begin
            val_next = ctl.clr ? '0 : d;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule
`default_nettype wire

### hw/rtl/bdre_div_unit.sv
// one long-division step: (rem * 256 + byte) divided by 2, 10 or 32
`default_nettype none
module bdre_div_unit (
    input  wire logic [1:0] base_sel,
    input  wire logic [4:0] rem_in,
    input  wire logic [7:0] byte_in,
    output logic [7:0]      quo,
    output logic [4:0]      rem_out
);

    logic [12:0] cur;
    logic [26:0] prod;
    logic [7:0]  q10;
    logic [12:0] diff10;

    assign cur = {rem_in, byte_in};
    // reciprocal of ten scaled by 2^16, exact for cur below 2560
    assign prod   = {14'd0, cur} * 27'd6554;
    assign q10    = prod[23:16];
    assign diff10 = cur - ({5'd0, q10} * 13'd10);

    always_comb
    begin
        case (base_sel)
            bdre_pkg::BASE_BIN:
            begin
                quo     = cur[8:1];
                rem_out = {4'd0, cur[0]};
            end
            bdre_pkg::BASE_DEC:
            begin
                quo     = q10;
                rem_out = diff10[4:0];
            end
            default:
            begin
                quo     = cur[12:5];
                rem_out = cur[4:0];
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/bytes_to_radix_digits_encoder_top.sv
// top level of the byte string to radix digit encoder
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | s_tdata in_byte, s_tlast last_byte
//  m_*      | out       | m_tvalid/m_tready  | m_tdata out_char, status; m_tlast last_out
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// bytes load one per cycle into a chain of BUFFER_BYTES byte cells.
// the final byte starts division passes unless the input is all zero or too long: each
// pass rotates the whole chain through the divider and yields one digit, then the
// characters of the clamped output length are emitted. input is held off during
// division, emission and error reporting; the output register absorbs stalls.
// reset is asynchronous active low; the byte and digit cells need no reset.
`default_nettype none
module bytes_to_radix_digits_encoder_top #(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [6:0] out_char, [8:7] status, rest zero
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_ERR  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] byte_cnt_reg, byte_cnt_next;
    logic          overlong_reg, overlong_next;
    logic          nz_reg, nz_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [4:0]    rem_reg, rem_next;
    logic          qnz_reg, qnz_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    err_reg, err_next;
    logic [1:0]    base_reg, base_next;
    logic [6:0]    olen_reg, olen_next;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    out_char_reg, out_char_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic          out_last_reg, out_last_next;

    logic [7:0]    bytes [BUFFER_BYTES];
    logic [4:0]    digs  [BUFFER_BYTES];
    logic [7:0]    quo;
    logic [4:0]    rem_out;
    logic [CW-1:0] len_eff;
    logic [CW-1:0] pad;
    logic          in_xfer, full, out_load, last_pass, push, pop;
    bdre_pkg::cell_ctl_t byte_ctl, byte_top_ctl, dig_ctl;

    assign s_tready  = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign full      = (byte_cnt_reg == CW'(BUFFER_BYTES));
    assign out_load  = !out_valid_reg || m_tready;
    assign last_pass = (pos_reg == PW'(BUFFER_BYTES - 1));

    always_comb
    begin
        if (olen_reg == 7'd0)
            len_eff = CW'(1);
        else if ({1'b0, olen_reg} > 8'(BUFFER_BYTES))
            len_eff = CW'(BUFFER_BYTES);
        else
            len_eff = CW'(olen_reg);
    end

    assign pad = len_eff - dcnt_reg;

    bdre_div_unit u_div (
        .base_sel (base_reg),
        .rem_in   (rem_reg),
        .byte_in  (bytes[0]),
        .quo      (quo),
        .rem_out  (rem_out)
    );

    // byte chain shifts toward cell 0; new bytes and quotients enter at the top
    assign byte_ctl     = {(in_xfer && !full) || (state_reg == S_DIV),
                           in_xfer && (byte_cnt_reg == '0)};
    assign byte_top_ctl = {byte_ctl.en, 1'b0};

    genvar k;
    generate
        for (k = 0; k < BUFFER_BYTES; k++)
        begin : g_byte
            if (k == BUFFER_BYTES - 1)
            begin : g_top
                bdre_cell #(.W(8)) u_cell (
                    .clk (clk),
                    .ctl (byte_top_ctl),
                    .d   ((state_reg == S_DIV) ? quo : s_tdata),
                    .q   (bytes[k])
                );
            end
            else
            begin : g_mid
                bdre_cell #(.W(8)) u_cell (
                    .clk (clk),
                    .ctl (byte_ctl),
                    .d   (bytes[k+1]),
                    .q   (bytes[k])
                );
            end
        end
    endgenerate

    // digit chain: push at cell 0 while dividing (msd ends at cell 0), pop from cell 0
    assign push = (state_reg == S_DIV) && last_pass && (dcnt_reg != len_eff);
    assign pop  = (state_reg == S_EMIT) && out_load && (idx_reg >= pad);
    assign dig_ctl = {push || pop, 1'b0};

    generate
        for (k = 0; k < BUFFER_BYTES; k++)
        begin : g_dig
            logic [4:0] d_in;
            if (k == 0)
            begin : g_first
                assign d_in = push ? rem_out : digs[1 % BUFFER_BYTES];
            end
            else if (k == BUFFER_BYTES - 1)
            begin : g_last
                assign d_in = push ? digs[k-1] : 5'd0;
            end
            else
            begin : g_mid
                assign d_in = push ? digs[k-1] : digs[k+1];
            end
            bdre_cell #(.W(5)) u_cell (
                .clk (clk),
                .ctl (dig_ctl),
                .d   (d_in),
                .q   (digs[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        byte_cnt_next   = byte_cnt_reg;
        overlong_next   = overlong_reg;
        nz_next         = nz_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        qnz_next        = qnz_reg;
        dcnt_next       = dcnt_reg;
        idx_next        = idx_reg;
        err_next        = err_reg;
        base_next       = base_reg;
        olen_next       = olen_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bdre_pkg::REG_BASE_SELECT:   base_next = cfg_data[1:0];
                bdre_pkg::REG_OUTPUT_LENGTH: olen_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_xfer)
                begin
                    if (full)
                    begin
                        overlong_next = 1'b1;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + CW'(1);
                        nz_next = ((byte_cnt_reg == '0) ? 1'b0 : nz_reg) || (s_tdata != 8'd0);
                    end
                    if (s_tlast)
                    begin
                        byte_cnt_next = '0;
                        overlong_next = 1'b0;
                        pos_next      = '0;
                        rem_next      = 5'd0;
                        qnz_next      = 1'b0;
                        dcnt_next     = '0;
                        idx_next      = '0;
                        if (overlong_reg || full)
                        begin
                            err_next   = bdre_pkg::ST_TOO_LONG;
                            state_next = S_ERR;
                        end
                        else if (nz_next)
                            state_next = S_DIV;
                        else
                            state_next = S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                if (last_pass)
                begin
                    if (dcnt_reg == len_eff)
                    begin
                        err_next   = bdre_pkg::ST_TOO_MANY;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg + CW'(1);
                        pos_next  = '0;
                        rem_next  = 5'd0;
                        qnz_next  = 1'b0;
                        // quotient all zero: the number is exhausted
                        if (!(qnz_reg || (quo != 8'd0)))
                            state_next = S_EMIT;
                    end
                end
                else
                begin
                    pos_next = pos_reg + PW'(1);
                    rem_next = rem_out;
                    qnz_next = qnz_reg || (quo != 8'd0);
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bdre_pkg::ST_OK;
                    out_char_next   = bdre_pkg::alpha_char(base_reg,
                                          (idx_reg < pad) ? 5'd0 : digs[0]);
                    out_last_next   = (idx_reg == len_eff - CW'(1));
                    idx_next        = idx_reg + CW'(1);
                    if (idx_reg == len_eff - CW'(1))
                        state_next = S_LOAD;
                end
            end
            S_ERR:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = err_reg;
                    out_char_next   = 7'd0;
                    out_last_next   = 1'b1;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            byte_cnt_reg  <= '0;
            overlong_reg  <= 1'b0;
            nz_reg        <= 1'b0;
            pos_reg       <= '0;
            rem_reg       <= 5'd0;
            qnz_reg       <= 1'b0;
            dcnt_reg      <= '0;
            idx_reg       <= '0;
            err_reg       <= bdre_pkg::ST_OK;
            base_reg      <= 2'd2;
            olen_reg      <= 7'd32;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            overlong_reg  <= overlong_next;
            nz_reg        <= nz_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            qnz_reg       <= qnz_next;
            dcnt_reg      <= dcnt_next;
            idx_reg       <= idx_next;
            err_reg       <= err_next;
            base_reg      <= base_next;
            olen_reg      <= olen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

`include "bytes_to_radix_digits_encoder_top_assert.svh"

    `BDRE_ASSERT_IMPL(a_no_input_while_dividing, state_reg == S_DIV, !s_tready)
    `BDRE_ASSERT_IMPL(a_digits_within_length, state_reg == S_EMIT, dcnt_reg <= len_eff)
    `BDRE_ASSERT_IMPL(a_error_is_last, m_tvalid && (m_tdata[8:7] != bdre_pkg::ST_OK), m_tlast)
    `BDRE_ASSERT_NEXT(a_error_then_load, (state_reg == S_ERR) && out_load, state_reg == S_LOAD)

endmodule
`default_nettype wire
